// ===== src/imu_sample_rotate_calibrate_assert.svh =====
// Assertion macros for the checker file of this block, isrc_check.sv.
`ifndef IMU_SAMPLE_ROTATE_CALIBRATE_ASSERT_SVH
`define IMU_SAMPLE_ROTATE_CALIBRATE_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define ISRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ISRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/isrc_pkg.sv =====
package isrc_pkg;

  localparam int RAW_W      = 16;
  localparam int SCALE_W    = 15;
  localparam int SCALE_SHIFT = 8;
  localparam int PROD1_W    = RAW_W + SCALE_W;
  localparam int VEC_W      = 22;
  localparam int COEF_W     = 16;
  localparam int ROT_PROD_W = COEF_W + VEC_W;
  localparam int ACC_W      = ROT_PROD_W + 2;
  localparam int ROT_SHIFT  = 14;
  localparam int ROT_W      = ACC_W - ROT_SHIFT;
  localparam int DIFF_W     = ROT_W + 1;
  localparam int AXIS_W     = 24;
  localparam int BIAS_W     = 24;
  localparam int ROW_W      = 3 * COEF_W;
  localparam int TEMP_W     = 12;
  localparam int CFG_IDX_W  = 3;

  // Degrees to radians per second and counts to g, both in Q8.16 after the shift.
  localparam logic signed [SCALE_W-1:0] GYRO_SCALE  = 15'sd8936;
  localparam logic signed [SCALE_W-1:0] ACCEL_SCALE = 15'sd3073;

  // 23 degrees in eighths.
  localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 12'sd184;

  localparam logic signed [DIFF_W-1:0] SAT_HI = 27'sd8388607;
  localparam logic signed [DIFF_W-1:0] SAT_LO = -27'sd8388608;
  localparam logic signed [AXIS_W-1:0] AXIS_MAX = 24'sh7FFFFF;
  localparam logic signed [AXIS_W-1:0] AXIS_MIN = 24'sh800000;

  localparam logic [ROW_W-1:0] ROT_X_RESET = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0] ROT_Y_RESET = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROT_Z_RESET = 48'h4000_0000_0000;

  typedef enum logic {
    KIND_GYRO  = 1'b0,
    KIND_ACCEL = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_X  = 3'd0,
    REG_ROT_Y  = 3'd1,
    REG_ROT_Z  = 3'd2,
    REG_BIAS_X = 3'd3,
    REG_BIAS_Y = 3'd4,
    REG_BIAS_Z = 3'd5
  } reg_idx_t;

  typedef logic signed [RAW_W-1:0]  raw_t;
  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [ROT_W-1:0]  rot_t;
  typedef logic signed [AXIS_W-1:0] axis_t;

  typedef struct packed {
    logic [2:0][ROW_W-1:0]  rot;
    logic [2:0][BIAS_W-1:0] bias;
  } cfg_t;

  // Side information that travels with each sample through the pipeline.
  typedef struct packed {
    logic                     op;
    logic signed [TEMP_W-1:0] temperature;
  } ctl_t;

endpackage

// ===== src/isrc_cfg.sv =====
module isrc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [isrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [isrc_pkg::ROW_W-1:0]     cfg_data,
  output isrc_pkg::cfg_t                 cfg
);

  isrc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot[0]  <= isrc_pkg::ROT_X_RESET;
      cfg_r.rot[1]  <= isrc_pkg::ROT_Y_RESET;
      cfg_r.rot[2]  <= isrc_pkg::ROT_Z_RESET;
      cfg_r.bias[0] <= '0;
      cfg_r.bias[1] <= '0;
      cfg_r.bias[2] <= '0;
    end else if (cfg_valid) begin
      unique case (isrc_pkg::reg_idx_t'(cfg_index))
        isrc_pkg::REG_ROT_X:  cfg_r.rot[0]  <= cfg_data;
        isrc_pkg::REG_ROT_Y:  cfg_r.rot[1]  <= cfg_data;
        isrc_pkg::REG_ROT_Z:  cfg_r.rot[2]  <= cfg_data;
        isrc_pkg::REG_BIAS_X: cfg_r.bias[0] <= cfg_data[isrc_pkg::BIAS_W-1:0];
        isrc_pkg::REG_BIAS_Y: cfg_r.bias[1] <= cfg_data[isrc_pkg::BIAS_W-1:0];
        isrc_pkg::REG_BIAS_Z: cfg_r.bias[2] <= cfg_data[isrc_pkg::BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/isrc_scale.sv =====
module isrc_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  isrc_pkg::raw_t     raw [3],
  input  logic [7:0]         temp_high,
  input  logic [7:0]         temp_low,
  output logic               out_valid,
  input  logic               out_ready,
  output isrc_pkg::vec_t     vec [3],
  output isrc_pkg::ctl_t     ctl
);

  logic                                  adv;
  logic signed [isrc_pkg::SCALE_W-1:0]   scale;
  logic signed [isrc_pkg::PROD1_W-1:0]   prod [3];
  logic [10:0]                           temp_raw;
  logic signed [isrc_pkg::TEMP_W-1:0]    temp_ext;
  isrc_pkg::vec_t                        vec_nxt [3];
  isrc_pkg::ctl_t                        ctl_nxt;
  logic                                  valid_r;
  isrc_pkg::vec_t                        vec_r [3];
  isrc_pkg::ctl_t                        ctl_r;

  assign adv      = !valid_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    scale = (op == isrc_pkg::KIND_ACCEL) ? isrc_pkg::ACCEL_SCALE : isrc_pkg::GYRO_SCALE;
    for (int i = 0; i < 3; i++) begin
      prod[i] = isrc_pkg::PROD1_W'(raw[i]) * isrc_pkg::PROD1_W'(scale);
      // The product fits 30 bits, so this slice is the floored shift by 8.
      vec_nxt[i] = prod[i][isrc_pkg::VEC_W+isrc_pkg::SCALE_SHIFT-1:isrc_pkg::SCALE_SHIFT];
    end
    temp_raw = {temp_high, temp_low[7:5]};
    temp_ext = {temp_raw[10], temp_raw};
    ctl_nxt.op = op;
    ctl_nxt.temperature = (op == isrc_pkg::KIND_ACCEL) ?
                          temp_ext + isrc_pkg::TEMP_OFFSET : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vec_r <= vec_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  assign out_valid = valid_r;
  assign vec       = vec_r;
  assign ctl       = ctl_r;

endmodule

// ===== src/isrc_rotate.sv =====
module isrc_rotate (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  isrc_pkg::vec_t     vec [3],
  input  isrc_pkg::ctl_t     ctl_in,
  input  isrc_pkg::cfg_t     cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output isrc_pkg::rot_t     rot [3],
  output isrc_pkg::ctl_t     ctl_out
);

  logic                                     adv_a;
  logic                                     adv_b;
  logic signed [isrc_pkg::COEF_W-1:0]       coef [3][3];
  logic signed [isrc_pkg::ROT_PROD_W-1:0]   prod_nxt [3][3];
  logic signed [isrc_pkg::ACC_W-1:0]        acc [3];
  isrc_pkg::rot_t                           rot_nxt [3];
  logic                                     valid_a_r;
  logic                                     valid_b_r;
  logic signed [isrc_pkg::ROT_PROD_W-1:0]   prod_r [3][3];
  isrc_pkg::ctl_t                           ctl_a_r;
  isrc_pkg::ctl_t                           ctl_b_r;
  isrc_pkg::rot_t                           rot_r [3];

  assign adv_b    = !valid_b_r || out_ready;
  assign adv_a    = !valid_a_r || adv_b;
  assign in_ready = adv_a;

  // Product stage: nine coefficient by axis multiplies.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef[r][c]     = cfg.rot[r][isrc_pkg::COEF_W*c +: isrc_pkg::COEF_W];
        prod_nxt[r][c] = isrc_pkg::ROT_PROD_W'(coef[r][c]) *
                         isrc_pkg::ROT_PROD_W'(vec[c]);
      end
    end
  end

  // Sum stage: three-term add per row, then the floored shift by 14.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = isrc_pkg::ACC_W'(prod_r[r][0]) + isrc_pkg::ACC_W'(prod_r[r][1]) +
               isrc_pkg::ACC_W'(prod_r[r][2]);
      rot_nxt[r] = acc[r][isrc_pkg::ACC_W-1:isrc_pkg::ROT_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else begin
      if (adv_a) begin
        valid_a_r <= in_valid;
      end
      if (adv_b) begin
        valid_b_r <= valid_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      prod_r  <= prod_nxt;
      ctl_a_r <= ctl_in;
    end
    if (adv_b) begin
      rot_r   <= rot_nxt;
      ctl_b_r <= ctl_a_r;
    end
  end

  assign out_valid = valid_b_r;
  assign rot       = rot_r;
  assign ctl_out   = ctl_b_r;

endmodule

// ===== src/isrc_correct.sv =====
module isrc_correct (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  isrc_pkg::rot_t                    rot [3],
  input  isrc_pkg::ctl_t                    ctl,
  input  isrc_pkg::cfg_t                    cfg,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              kind,
  output isrc_pkg::axis_t                   axis [3],
  output logic signed [isrc_pkg::TEMP_W-1:0] temperature,
  output logic                              temp_valid,
  output logic                              saturated
);

  logic                                adv;
  logic signed [isrc_pkg::DIFF_W-1:0]  bias_ext [3];
  logic signed [isrc_pkg::DIFF_W-1:0]  diff [3];
  logic [2:0]                          clip;
  isrc_pkg::axis_t                     axis_nxt [3];
  logic                                valid_r;
  logic                                kind_r;
  isrc_pkg::axis_t                     axis_r [3];
  logic signed [isrc_pkg::TEMP_W-1:0]  temp_r;
  logic                                sat_r;

  assign adv      = !valid_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // Offsets apply to gyro samples only.
      bias_ext[i] = (ctl.op == isrc_pkg::KIND_GYRO) ?
                    isrc_pkg::DIFF_W'($signed(cfg.bias[i])) : '0;
      diff[i] = isrc_pkg::DIFF_W'(rot[i]) - bias_ext[i];
      if (diff[i] > isrc_pkg::SAT_HI) begin
        axis_nxt[i] = isrc_pkg::AXIS_MAX;
        clip[i]     = 1'b1;
      end else if (diff[i] < isrc_pkg::SAT_LO) begin
        axis_nxt[i] = isrc_pkg::AXIS_MIN;
        clip[i]     = 1'b1;
      end else begin
        axis_nxt[i] = diff[i][isrc_pkg::AXIS_W-1:0];
        clip[i]     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r <= ctl.op;
      axis_r <= axis_nxt;
      temp_r <= ctl.temperature;
      sat_r  <= |clip;
    end
  end

  assign out_valid   = valid_r;
  assign kind        = kind_r;
  assign axis        = axis_r;
  assign temperature = temp_r;
  assign temp_valid  = kind_r;
  assign saturated   = sat_r;

endmodule

// ===== src/imu_sample_rotate_calibrate.sv =====
// Channel   Direction  Handshake             Contents
// in_       input      in_valid / in_ready   sample kind, three raw axes, temperature bytes
// out_      output     out_valid / out_ready kind, three Q8.16 axes, temperature, flags
// cfg_      input      cfg_valid / cfg_ready register index and write data
//
// One sample is taken per cycle unless a full stage is stalled by out_ready. The four
// register stages are axis scaling, the nine matrix products, the row sums, and the bias
// subtraction with saturation into the output register, where out_valid rises.
// Each stage holds only while its successor is full and stalled, so bubbles close up.
// rst_n (synchronous) empties the pipeline and loads the identity matrix and zero offsets.
// cfg_ready is always high; a register write takes effect on the next cycle.
module imu_sample_rotate_calibrate (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic signed [15:0]                in_raw_x,
  input  logic signed [15:0]                in_raw_y,
  input  logic signed [15:0]                in_raw_z,
  input  logic [7:0]                        in_temp_high,
  input  logic [7:0]                        in_temp_low,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_kind,
  output logic signed [23:0]                out_x,
  output logic signed [23:0]                out_y,
  output logic signed [23:0]                out_z,
  output logic signed [11:0]                out_temperature,
  output logic                              out_temp_valid,
  output logic                              out_saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [isrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [isrc_pkg::ROW_W-1:0]        cfg_data
);

  isrc_pkg::cfg_t  cfg;
  isrc_pkg::raw_t  raw [3];
  logic            s1_valid;
  logic            s1_ready;
  isrc_pkg::vec_t  s1_vec [3];
  isrc_pkg::ctl_t  s1_ctl;
  logic            s3_valid;
  logic            s3_ready;
  isrc_pkg::rot_t  s3_rot [3];
  isrc_pkg::ctl_t  s3_ctl;
  isrc_pkg::axis_t axis [3];

  assign cfg_ready = 1'b1;
  assign raw[0] = in_raw_x;
  assign raw[1] = in_raw_y;
  assign raw[2] = in_raw_z;

  isrc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  isrc_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (in_op),
    .raw       (raw),
    .temp_high (in_temp_high),
    .temp_low  (in_temp_low),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .vec       (s1_vec),
    .ctl       (s1_ctl)
  );

  isrc_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .vec       (s1_vec),
    .ctl_in    (s1_ctl),
    .cfg       (cfg),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .rot       (s3_rot),
    .ctl_out   (s3_ctl)
  );

  isrc_correct u_correct (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (s3_valid),
    .in_ready    (s3_ready),
    .rot         (s3_rot),
    .ctl         (s3_ctl),
    .cfg         (cfg),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (out_kind),
    .axis        (axis),
    .temperature (out_temperature),
    .temp_valid  (out_temp_valid),
    .saturated   (out_saturated)
  );

  assign out_x = axis[0];
  assign out_y = axis[1];
  assign out_z = axis[2];

endmodule

// ===== src/isrc_check.sv =====
`include "imu_sample_rotate_calibrate_assert.svh"

module isrc_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_op,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_kind,
  input logic signed [23:0] out_x,
  input logic signed [23:0] out_y,
  input logic signed [23:0] out_z,
  input logic signed [11:0] out_temperature,
  input logic               out_temp_valid,
  input logic               out_saturated
);

  // A stalled result keeps its axes, kind and saturation flag.
  `ISRC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(out_kind) && $stable(out_saturated), "stalled result changed")

  // The pipeline is empty right after reset.
  `ISRC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result shown after reset")

  // With out_ready held high, a transferred sample reaches the output with its kind intact.
  `ISRC_ASSERT(a_latency, in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid && out_kind == $past(in_op, 4), "sample lost or out of order")

  // Gyro results carry no temperature; accel results always do.
  `ISRC_ASSERT(a_temp_kind, out_valid |-> out_temp_valid == out_kind && (out_kind || out_temperature == 12'sd0), "temperature field inconsistent with kind")

endmodule

bind imu_sample_rotate_calibrate isrc_check u_isrc_check (.*);
